// File: design/drc_pkg.sv
// ----------------------------------------------------------------------------
// drc_pkg
// Shared types, constants and the elaboration-time sine threshold table for
// the depth rainbow colorizer.
// ----------------------------------------------------------------------------
package drc_pkg;

   // field widths
   localparam int DEPTH_W = 16;
   localparam int COORD_W = 10;
   localparam int SPAN_W  = 11;
   localparam int CHAN_W  = 8;

   // frame and sine table sizes
   localparam int MAX_DIM          = 1024;
   localparam int SINE_TABLE_DEPTH = 1024;

   // compare width for the frame bound test, wide enough for column and MAX_DIM
   localparam int DIM_CMP_W = ((COORD_W + 1) > $clog2(MAX_DIM + 1)) ?
                              (COORD_W + 1) : $clog2(MAX_DIM + 1);
   // rectangle end (start + span) never wraps
   localparam int END_W = SPAN_W + 1;

   // normalized depth t in Q1.16, 0..1 inclusive
   localparam int Q_FRAC = 16;
   localparam int T_W    = Q_FRAC + 1;
   // quarter-wave argument, 0..quarter inclusive
   localparam int U_W    = Q_FRAC - 1;
   localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int PROD_W = U_W + IDX_W;
   localparam int IDX_SHIFT  = Q_FRAC - 2;
   localparam int ROUND_HALF = 1 << (Q_FRAC - 3);

   localparam logic [T_W-1:0] Q_QUARTER  = T_W'(1 << (Q_FRAC - 2));
   localparam logic [T_W-1:0] Q_HALF     = T_W'(1 << (Q_FRAC - 1));
   localparam logic [T_W-1:0] Q_3QUARTER = T_W'(3 << (Q_FRAC - 2));
   localparam logic [T_W-1:0] Q_ONE      = T_W'(1 << Q_FRAC);

   // output levels and the search over them
   localparam int LVL_W       = CHAN_W;
   localparam int LVL_COUNT   = 1 << LVL_W;
   localparam int SRCH_STAGES = LVL_W;
   localparam logic [CHAN_W-1:0] CHAN_FULL = '1;
   localparam logic [CHAN_W-1:0] CHAN_NONE = '0;

   // divider split
   localparam int DIV_STAGES = 4;
   localparam int DIV_STEP   = Q_FRAC / DIV_STAGES;

   // register file
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = DEPTH_W;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_MIN   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_MAX   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_RECT_LEFT   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_RECT_TOP    = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_RECT_WIDTH  = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_RECT_HEIGHT = CSR_IDX_W'(5);

   // rainbow segment codes
   localparam int SEG_W = 2;
   localparam logic [SEG_W-1:0] SEG_RISE_GREEN = 2'd0;
   localparam logic [SEG_W-1:0] SEG_FALL_BLUE  = 2'd1;
   localparam logic [SEG_W-1:0] SEG_RISE_RED   = 2'd2;
   localparam logic [SEG_W-1:0] SEG_FALL_GREEN = 2'd3;

   // pi/2 in Q62, and its split over the table depth
   localparam logic [63:0] HALF_PI_Q62  = 64'h6487ED5110B4611A;
   localparam logic [63:0] HALF_PI_STEP = HALF_PI_Q62 / 64'(SINE_TABLE_DEPTH);
   localparam logic [63:0] HALF_PI_REM  = HALF_PI_Q62 % 64'(SINE_TABLE_DEPTH);

   typedef struct packed {
      logic [DEPTH_W-1:0] depth;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
      logic              colorized;
   } rsp_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] depth_min;
      logic [DEPTH_W-1:0] depth_max;
      logic [COORD_W-1:0] rect_left;
      logic [COORD_W-1:0] rect_top;
      logic [SPAN_W-1:0]  rect_width;
      logic [SPAN_W-1:0]  rect_height;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      depth_min:   '0,
      depth_max:   '1,
      rect_left:   '0,
      rect_top:    '0,
      rect_width:  '0,
      rect_height: '0
   };

   // per-item flags that ride along the pipeline
   typedef struct packed {
      logic              colorize;
      logic              below;
      logic              above;
      logic [CHAN_W-1:0] gray;
   } side_type;

   // divider stage contents
   typedef struct packed {
      side_type           side;
      logic [DEPTH_W-1:0] aden;
      logic [DEPTH_W-1:0] rem;
      logic [T_W-1:0]     quo;
   } div_type;

   // sine search stage contents
   typedef struct packed {
      side_type          side;
      logic [SEG_W-1:0]  seg;
      logic [IDX_W-1:0]  idx;
      logic [LVL_W-1:0]  lvl;
   } srch_type;

   // first table index at which each output level is reached
   typedef logic [LVL_COUNT-1:0][IDX_W-1:0] thr_tab_type;

   // (a * b) >> 62, low 64 bits
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // floor(255 * sin(pi/2 * k / D)) by Taylor series in Q62
   function automatic logic [CHAN_W-1:0] sine_entry(input logic [63:0] k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      x = HALF_PI_STEP * k + (HALF_PI_REM * k) / 64'(SINE_TABLE_DEPTH);
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      // eleven series terms, divisor (2n)(2n+1), alternating sign
      term = mul_q62(term, x2) / 64'd6;
      sum  = sum - term;
      term = mul_q62(term, x2) / 64'd20;
      sum  = sum + term;
      term = mul_q62(term, x2) / 64'd42;
      sum  = sum - term;
      term = mul_q62(term, x2) / 64'd72;
      sum  = sum + term;
      term = mul_q62(term, x2) / 64'd110;
      sum  = sum - term;
      term = mul_q62(term, x2) / 64'd156;
      sum  = sum + term;
      term = mul_q62(term, x2) / 64'd210;
      sum  = sum - term;
      term = mul_q62(term, x2) / 64'd272;
      sum  = sum + term;
      term = mul_q62(term, x2) / 64'd342;
      sum  = sum - term;
      term = mul_q62(term, x2) / 64'd420;
      sum  = sum + term;
      term = mul_q62(term, x2) / 64'd506;
      sum  = sum - term;
      sum = sum + (64'd1 << 20);
      v   = ((sum >> 6) * 64'd255) >> 56;
      return (v > 64'd255) ? CHAN_FULL : v[CHAN_W-1:0];
   endfunction

   // the quarter wave is nondecreasing, so level v is shown from index thr[v] on
   function automatic thr_tab_type build_thr();
      thr_tab_type tab;
      int          lvl;
      int          s;
      int          k;
      tab = '0;
      lvl = 0;
      for (k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         s = int'(sine_entry(64'(k)));
         while (lvl < s) begin
            lvl = lvl + 1;
            tab[lvl] = IDX_W'(k);
         end
      end
      return tab;
   endfunction

   localparam thr_tab_type SINE_THR = build_thr();

endpackage

// File: design/drc_prep.sv
// ----------------------------------------------------------------------------
// drc_prep
// Two front stages: rectangle and range tests, the below-range flag, depth
// offset and span, then the above-range flag and the integer quotient bit.
// ----------------------------------------------------------------------------
module drc_prep (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  drc_pkg::req_type in_data,
   input  drc_pkg::cfg_type cfg,
   output logic             out_valid,
   output drc_pkg::div_type out_data
);
   import drc_pkg::*;

   logic               a_vld_ff;
   side_type           a_side_ff;
   side_type           a_side_in;
   logic [DEPTH_W-1:0] a_anum_ff;
   logic [DEPTH_W-1:0] a_anum_in;
   logic [DEPTH_W-1:0] a_aden_ff;
   logic [DEPTH_W-1:0] a_aden_in;
   logic               b_vld_ff;
   div_type            b_data_ff;
   div_type            b_data_in;

   logic [END_W-1:0] col_end;
   logic [END_W-1:0] row_end;
   logic             in_frame;
   logic             in_rect;
   logic             num_neg;
   logic             den_neg;
   logic             ge;

   // stage A: position and range tests
   always_comb begin
      col_end  = END_W'(cfg.rect_left) + END_W'(cfg.rect_width);
      row_end  = END_W'(cfg.rect_top) + END_W'(cfg.rect_height);
      in_frame = (DIM_CMP_W'(in_data.column) < DIM_CMP_W'(MAX_DIM)) &&
                 (DIM_CMP_W'(in_data.row) < DIM_CMP_W'(MAX_DIM));
      in_rect  = (in_data.column >= cfg.rect_left) &&
                 (END_W'(in_data.column) < col_end) &&
                 (in_data.row >= cfg.rect_top) &&
                 (END_W'(in_data.row) < row_end);
      num_neg  = in_data.depth < cfg.depth_min;
      den_neg  = cfg.depth_max < cfg.depth_min;
      a_anum_in = num_neg ? (cfg.depth_min - in_data.depth) :
                            (in_data.depth - cfg.depth_min);
      a_aden_in = den_neg ? (cfg.depth_min - cfg.depth_max) :
                            (cfg.depth_max - cfg.depth_min);
      a_side_in.colorize = in_frame && in_rect && (cfg.depth_min != cfg.depth_max);
      a_side_in.below    = (in_data.depth != cfg.depth_min) && (num_neg != den_neg);
      a_side_in.above    = 1'b0;
      a_side_in.gray     = (|in_data.depth[DEPTH_W-1:CHAN_W]) ? CHAN_FULL :
                                                               in_data.depth[CHAN_W-1:0];
   end

   // stage B: above-range flag and the integer bit of the quotient
   always_comb begin
      ge                   = a_anum_ff >= a_aden_ff;
      b_data_in.side       = a_side_ff;
      b_data_in.side.above = a_anum_ff > a_aden_ff;
      b_data_in.aden       = a_aden_ff;
      b_data_in.rem        = ge ? (a_anum_ff - a_aden_ff) : a_anum_ff;
      b_data_in.quo        = '0;
      b_data_in.quo[Q_FRAC] = ge;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else if (enable) begin
         a_vld_ff <= in_valid;
         b_vld_ff <= a_vld_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (enable) begin
         a_side_ff <= a_side_in;
         a_anum_ff <= a_anum_in;
         a_aden_ff <= a_aden_in;
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_vld_ff;
   assign out_data  = b_data_ff;

endmodule

// File: design/drc_div.sv
// ----------------------------------------------------------------------------
// drc_div
// Pipelined restoring divider for the 16 fraction bits of t, a fixed number
// of quotient bits per stage.
// ----------------------------------------------------------------------------
module drc_div (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  drc_pkg::div_type in_data,
   output logic             out_valid,
   output drc_pkg::div_type out_data
);
   import drc_pkg::*;

   div_type               src      [DIV_STAGES];
   div_type               stage_ff [DIV_STAGES];
   div_type               stage_in [DIV_STAGES];
   logic [DIV_STAGES-1:0] vld_ff;

   // stage inputs
   always_comb begin
      src[0] = in_data;
      for (int s = 1; s < DIV_STAGES; s++) begin
         src[s] = stage_ff[s-1];
      end
   end

   // DIV_STEP shift-compare-subtract steps per stage
   always_comb begin
      logic [DEPTH_W:0] wide;
      for (int s = 0; s < DIV_STAGES; s++) begin
         stage_in[s] = src[s];
         for (int j = 0; j < DIV_STEP; j++) begin
            wide = {stage_in[s].rem, 1'b0};
            if (wide >= {1'b0, stage_in[s].aden}) begin
               stage_in[s].quo[Q_FRAC-1-s*DIV_STEP-j] = 1'b1;
               wide = wide - {1'b0, stage_in[s].aden};
            end
            stage_in[s].rem = wide[DEPTH_W-1:0];
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[DIV_STAGES-2:0], in_valid};
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign out_valid = vld_ff[DIV_STAGES-1];
   assign out_data  = stage_ff[DIV_STAGES-1];

endmodule

// File: design/drc_sine.sv
// ----------------------------------------------------------------------------
// drc_sine
// Segment select, quarter-wave index, a one-bit-per-stage search of the
// sine level thresholds, and the final color mux.
// ----------------------------------------------------------------------------
module drc_sine (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  drc_pkg::div_type in_data,
   output logic             out_valid,
   output drc_pkg::rsp_type out_data
);
   import drc_pkg::*;

   localparam int VLD_N = SRCH_STAGES + 2;

   logic [VLD_N-1:0] vld_ff;

   side_type         c_side_ff;
   logic [SEG_W-1:0] c_seg_ff;
   logic [SEG_W-1:0] c_seg_in;
   logic [U_W-1:0]   c_u_ff;
   logic [U_W-1:0]   c_u_in;

   srch_type          d_ff;
   srch_type          d_in;
   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] shifted;

   srch_type          src     [SRCH_STAGES];
   srch_type          srch_ff [SRCH_STAGES];
   srch_type          srch_in [SRCH_STAGES];
   srch_type          last;

   // stage C: pick the rainbow segment and fold t onto the quarter wave
   always_comb begin
      priority if (in_data.quo <= Q_QUARTER) begin
         c_seg_in = SEG_RISE_GREEN;
         c_u_in   = in_data.quo[U_W-1:0];
      end else if (in_data.quo <= Q_HALF) begin
         c_seg_in = SEG_FALL_BLUE;
         c_u_in   = U_W'(Q_HALF - in_data.quo);
      end else if (in_data.quo <= Q_3QUARTER) begin
         c_seg_in = SEG_RISE_RED;
         c_u_in   = U_W'(in_data.quo - Q_HALF);
      end else begin
         c_seg_in = SEG_FALL_GREEN;
         c_u_in   = U_W'(Q_ONE - in_data.quo);
      end
   end

   // stage D: table index, rounded to nearest and clamped
   always_comb begin
      prod       = PROD_W'(c_u_ff) * PROD_W'(SINE_TABLE_DEPTH) + PROD_W'(ROUND_HALF);
      shifted    = prod >> IDX_SHIFT;
      d_in.side  = c_side_ff;
      d_in.seg   = c_seg_ff;
      d_in.idx   = (shifted > PROD_W'(SINE_TABLE_DEPTH)) ? IDX_W'(SINE_TABLE_DEPTH) :
                                                           shifted[IDX_W-1:0];
      d_in.lvl   = '0;
   end

   // search stages: level = largest v with thr[v] <= idx, MSB first
   always_comb begin
      src[0] = d_ff;
      for (int s = 1; s < SRCH_STAGES; s++) begin
         src[s] = srch_ff[s-1];
      end
   end

   always_comb begin
      logic [LVL_W-1:0] cand;
      for (int s = 0; s < SRCH_STAGES; s++) begin
         srch_in[s] = src[s];
         cand = src[s].lvl;
         cand[LVL_W-1-s] = 1'b1;
         if (SINE_THR[cand] <= src[s].idx) begin
            srch_in[s].lvl = cand;
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[VLD_N-2:0], in_valid};
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (enable) begin
         c_side_ff <= in_data.side;
         c_seg_ff  <= c_seg_in;
         c_u_ff    <= c_u_in;
         d_ff      <= d_in;
         for (int s = 0; s < SRCH_STAGES; s++) begin
            srch_ff[s] <= srch_in[s];
         end
      end
   end

   // final color mux
   assign last = srch_ff[SRCH_STAGES-1];

   always_comb begin
      out_data.colorized = last.side.colorize;
      priority if (!last.side.colorize) begin
         out_data.blue  = last.side.gray;
         out_data.green = last.side.gray;
         out_data.red   = last.side.gray;
      end else if (last.side.below) begin
         out_data.blue  = CHAN_FULL;
         out_data.green = CHAN_NONE;
         out_data.red   = CHAN_NONE;
      end else if (last.side.above) begin
         out_data.blue  = CHAN_NONE;
         out_data.green = CHAN_NONE;
         out_data.red   = CHAN_FULL;
      end else begin
         unique case (last.seg)
            SEG_RISE_GREEN: begin
               out_data.blue  = CHAN_FULL;
               out_data.green = last.lvl;
               out_data.red   = CHAN_NONE;
            end
            SEG_FALL_BLUE: begin
               out_data.blue  = last.lvl;
               out_data.green = CHAN_FULL;
               out_data.red   = CHAN_NONE;
            end
            SEG_RISE_RED: begin
               out_data.blue  = CHAN_NONE;
               out_data.green = CHAN_FULL;
               out_data.red   = last.lvl;
            end
            SEG_FALL_GREEN: begin
               out_data.blue  = CHAN_NONE;
               out_data.green = last.lvl;
               out_data.red   = CHAN_FULL;
            end
            default: begin
               out_data.blue  = CHAN_NONE;
               out_data.green = CHAN_NONE;
               out_data.red   = CHAN_NONE;
            end
         endcase
      end
   end

   assign out_valid = vld_ff[VLD_N-1];

endmodule

// File: design/depth_rainbow_colorizer_core.sv
// ----------------------------------------------------------------------------
// depth_rainbow_colorizer_core
// Colorizes a depth pixel stream on a sine rainbow inside a configured
// rectangle, gray elsewhere.
//
//   channel  direction  handshake             payload
//   req_     in         req_valid / req_stall  depth, column, row
//   rsp_     out        rsp_valid / rsp_stall  blue, green, red, colorized
//   csr_     in         csr_wr_en              csr_index, csr_data
//
// One item per clock sustained while rsp_stall is low. Seventeen register
// stages from input to rsp_data: two front stages, four divider stages, two
// index stages, eight sine search stages and the output register.
// Synchronous reset clears all valid bits and loads the register defaults.
// All stages but the output register hold together while the skid is full;
// req_stall is that skid flag, so the input side is one register from rsp_stall.
// ----------------------------------------------------------------------------
module depth_rainbow_colorizer_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  drc_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output drc_pkg::rsp_type                   rsp_data,
   input  logic                               csr_wr_en,
   input  logic [drc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [drc_pkg::CSR_DATA_W-1:0]     csr_data
);
   import drc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   logic    enable;
   logic    prep_vld;
   div_type prep_data;
   logic    div_vld;
   div_type div_data;
   logic    sine_vld;
   rsp_type sine_data;
   logic    pipe_vld;

   logic    out_vld_ff;
   logic    out_vld_in;
   rsp_type out_data_ff;
   rsp_type out_data_in;
   logic    skid_vld_ff;
   logic    skid_vld_in;
   rsp_type skid_data_ff;
   rsp_type skid_data_in;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      unique case (csr_index)
         CSR_DEPTH_MIN:   cfg_in.depth_min   = csr_data[DEPTH_W-1:0];
         CSR_DEPTH_MAX:   cfg_in.depth_max   = csr_data[DEPTH_W-1:0];
         CSR_RECT_LEFT:   cfg_in.rect_left   = csr_data[COORD_W-1:0];
         CSR_RECT_TOP:    cfg_in.rect_top    = csr_data[COORD_W-1:0];
         CSR_RECT_WIDTH:  cfg_in.rect_width  = csr_data[SPAN_W-1:0];
         CSR_RECT_HEIGHT: cfg_in.rect_height = csr_data[SPAN_W-1:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_wr_en) begin
         cfg_ff <= cfg_in;
      end
   end

   // the whole pipeline moves unless the skid register holds an item
   assign enable    = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   drc_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .cfg       (cfg_ff),
      .out_valid (prep_vld),
      .out_data  (prep_data)
   );

   drc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (prep_vld),
      .in_data   (prep_data),
      .out_valid (div_vld),
      .out_data  (div_data)
   );

   drc_sine u_sine (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (div_vld),
      .in_data   (div_data),
      .out_valid (sine_vld),
      .out_data  (sine_data)
   );

   // last stage item leaves the pipeline only on an enabled cycle
   assign pipe_vld = enable && sine_vld;

   // output register with skid
   always_comb begin
      out_vld_in   = out_vld_ff;
      out_data_in  = out_data_ff;
      skid_vld_in  = skid_vld_ff;
      skid_data_in = skid_data_ff;
      if (!out_vld_ff || !rsp_stall) begin
         if (skid_vld_ff) begin
            out_vld_in  = 1'b1;
            out_data_in = skid_data_ff;
            skid_vld_in = 1'b0;
         end else begin
            out_vld_in  = pipe_vld;
            out_data_in = sine_data;
         end
      end else if (pipe_vld) begin
         skid_vld_in  = 1'b1;
         skid_data_in = sine_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

endmodule

// File: design/drc_checker.sv
// ----------------------------------------------------------------------------
// drc_checker
// Port-level checks on the colorizer result stream and the input stall, bound to the top level.
// ----------------------------------------------------------------------------
module drc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input drc_pkg::rsp_type rsp_data
);
   import drc_pkg::*;

   // a stalled result stays up and unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // reset empties the result side and releases the input side
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or stall present after reset");

   // gray passthrough shows one value on all three channels
   a_gray_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.colorized |->
         (rsp_data.blue == rsp_data.green) && (rsp_data.green == rsp_data.red))
      else $error("gray pixel with unequal channels");

   // every rainbow color has one full channel and never mixes blue with red
   a_rainbow_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.colorized |->
         ((rsp_data.blue == CHAN_FULL) || (rsp_data.green == CHAN_FULL) ||
          (rsp_data.red == CHAN_FULL)) &&
         ((rsp_data.blue == CHAN_NONE) || (rsp_data.red == CHAN_NONE)))
      else $error("rainbow pixel off the color path");

   // the input side only stalls while a result is held back
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall && req_valid |-> rsp_valid && $past(rsp_stall))
      else $error("input stalled without a held result");

endmodule

bind depth_rainbow_colorizer_core drc_checker u_drc_checker (.*);

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the depth rainbow colorizer. Pixels are queued by a
// phase sequencer, driven with random gaps, and every result is checked
// against an in-bench rainbow predictor built from the register writes seen
// on the csr port.
// ----------------------------------------------------------------------------
module tb_top;
   import drc_pkg::*;

   localparam int CLK_HALF     = 10;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 24;
   localparam int PHASE_COUNT  = 14;
   localparam int PHASE_ITEMS  = 130;
   localparam int HOLD_CYCLES  = 300;

   // unused register slots, writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] SPARE_REG_A = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] SPARE_REG_B = CSR_IDX_W'(7);

   // normalized depth breakpoints in Q1.16
   localparam int T_QUARTER   = 16384;
   localparam int T_HALF      = 32768;
   localparam int T_3QUARTER  = 49152;
   localparam int T_ONE       = 65536;
   localparam logic [63:0] PI_HALF_Q62 = 64'h6487ED5110B4611A;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   // register copies, updated from the csr port
   logic [DEPTH_W-1:0] cfg_depth_min   = '0;
   logic [DEPTH_W-1:0] cfg_depth_max   = '1;
   logic [COORD_W-1:0] cfg_rect_left   = '0;
   logic [COORD_W-1:0] cfg_rect_top    = '0;
   logic [SPAN_W-1:0]  cfg_rect_width  = '0;
   logic [SPAN_W-1:0]  cfg_rect_height = '0;

   logic [CHAN_W-1:0] quarter_wave [0:SINE_TABLE_DEPTH];

   req_type pixel_backlog [$];
   rsp_type color_expect [$];
   rsp_type oldest_color;

   logic req_fire       = 1'b0;
   bit   idle_on        = 1'b1;
   int   src_gap        = 0;
   int   sink_burst     = 0;
   int   sink_hold      = 0;
   int   mismatch_count = 0;
   int   cycle_count    = 0;

   depth_rainbow_colorizer_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #CLK_HALF clock = ~clock;

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------
   function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] wide;
      wide = 128'(a) * 128'(b);
      return 64'(wide >> 62);
   endfunction

   // floor(255 * sin(pi/2 * k / depth)), Taylor series in Q62 with a tiny bias
   function automatic logic [CHAN_W-1:0] quarter_sine(input int k);
      logic [63:0] ang;
      logic [63:0] ang_sq;
      logic [63:0] term;
      logic [63:0] acc;
      logic [63:0] lvl;
      int          n;
      ang = (PI_HALF_Q62 / 64'(SINE_TABLE_DEPTH)) * 64'(k) +
            ((PI_HALF_Q62 % 64'(SINE_TABLE_DEPTH)) * 64'(k)) / 64'(SINE_TABLE_DEPTH);
      ang_sq = q62_product(ang, ang);
      term   = ang;
      acc    = ang;
      for (n = 1; n <= 11; n++) begin
         term = q62_product(term, ang_sq) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      acc = acc + (64'd1 << 20);
      lvl = ((acc >> 6) * 64'd255) >> 56;
      return (lvl > 64'd255) ? 8'd255 : lvl[7:0];
   endfunction

   // quarter-wave level for a Q0.16 argument, index rounded half up
   function automatic logic [CHAN_W-1:0] sine_level(input int u);
      int idx;
      idx = (u * SINE_TABLE_DEPTH + 8192) >>> 14;
      if (idx > SINE_TABLE_DEPTH) begin
         idx = SINE_TABLE_DEPTH;
      end
      return quarter_wave[idx];
   endfunction

   function automatic rsp_type colorize_pixel(input req_type px);
      rsp_type            res;
      int                 col_end;
      int                 row_end;
      logic               in_rect;
      logic               num_neg;
      logic               den_neg;
      logic [DEPTH_W-1:0] anum;
      logic [DEPTH_W-1:0] aden;
      logic [31:0]        ratio;
      int                 t;
      logic [CHAN_W-1:0]  gray;
      col_end = int'(cfg_rect_left) + int'(cfg_rect_width);
      row_end = int'(cfg_rect_top) + int'(cfg_rect_height);
      in_rect = int'(px.column) < MAX_DIM && int'(px.row) < MAX_DIM &&
                px.column >= cfg_rect_left && int'(px.column) < col_end &&
                px.row >= cfg_rect_top && int'(px.row) < row_end;
      gray = (px.depth > 16'd255) ? 8'd255 : px.depth[7:0];
      res  = '{blue: gray, green: gray, red: gray, colorized: 1'b0};
      if (in_rect && cfg_depth_min != cfg_depth_max) begin
         num_neg = px.depth < cfg_depth_min;
         den_neg = cfg_depth_max < cfg_depth_min;
         anum = num_neg ? cfg_depth_min - px.depth : px.depth - cfg_depth_min;
         aden = den_neg ? cfg_depth_min - cfg_depth_max : cfg_depth_max - cfg_depth_min;
         res.colorized = 1'b1;
         if (anum != 0 && num_neg != den_neg) begin
            // below range: pure blue
            res.blue  = 8'd255;
            res.green = 8'd0;
            res.red   = 8'd0;
         end else if (anum > aden) begin
            // above range: pure red
            res.blue  = 8'd0;
            res.green = 8'd0;
            res.red   = 8'd255;
         end else begin
            ratio = {anum, 16'd0} / {16'd0, aden};
            t = int'(ratio);
            if (t <= T_QUARTER) begin
               res.blue  = 8'd255;
               res.green = sine_level(t);
               res.red   = 8'd0;
            end else if (t <= T_HALF) begin
               res.blue  = sine_level(T_HALF - t);
               res.green = 8'd255;
               res.red   = 8'd0;
            end else if (t <= T_3QUARTER) begin
               res.blue  = 8'd0;
               res.green = 8'd255;
               res.red   = sine_level(t - T_HALF);
            end else begin
               res.blue  = 8'd0;
               res.green = sine_level(T_ONE - t);
               res.red   = 8'd255;
            end
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // pixel driver: new item on the falling edge once the last one was taken
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (src_gap > 0) begin
            src_gap = src_gap - 1;
            req_valid <= 1'b0;
         end else if (pixel_backlog.size() != 0) begin
            req_data  <= pixel_backlog.pop_front();
            req_valid <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) begin
               src_gap = $urandom_range(1, 14);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side back-pressure: long hold-off first, then random bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (sink_hold > 0) begin
         sink_hold = sink_hold - 1;
         rsp_stall <= 1'b1;
      end else if (sink_burst > 0) begin
         sink_burst = sink_burst - 1;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         sink_burst = $urandom_range(0, 13);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // monitor: predict on accept, track register writes, check results
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            color_expect.push_back(colorize_pixel(req_data));
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_DEPTH_MIN:   cfg_depth_min   = csr_data;
               CSR_DEPTH_MAX:   cfg_depth_max   = csr_data;
               CSR_RECT_LEFT:   cfg_rect_left   = csr_data[COORD_W-1:0];
               CSR_RECT_TOP:    cfg_rect_top    = csr_data[COORD_W-1:0];
               CSR_RECT_WIDTH:  cfg_rect_width  = csr_data[SPAN_W-1:0];
               CSR_RECT_HEIGHT: cfg_rect_height = csr_data[SPAN_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (color_expect.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected pixel b/g/r/c = %0d/%0d/%0d/%0d", $realtime,
                        rsp_data.blue, rsp_data.green, rsp_data.red, rsp_data.colorized);
            end else begin
               oldest_color = color_expect.pop_front();
               if (rsp_data.blue !== oldest_color.blue ||
                   rsp_data.green !== oldest_color.green ||
                   rsp_data.red !== oldest_color.red ||
                   rsp_data.colorized !== oldest_color.colorized) begin
                  mismatch_count++;
                  $display("%0t: pixel mismatch, expected b/g/r/c = %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                           $realtime, oldest_color.blue, oldest_color.green,
                           oldest_color.red, oldest_color.colorized, rsp_data.blue,
                           rsp_data.green, rsp_data.red, rsp_data.colorized);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[depth_rainbow_colorizer_core] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // sequencer helpers
   // ---------------------------------------------------------------------
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // every register, junk in the bits above each register's width
   task automatic write_window(input int dmin, input int dmax, input int left,
                               input int top, input int w, input int h);
      write_reg(CSR_DEPTH_MIN, 16'(dmin));
      write_reg(CSR_DEPTH_MAX, 16'(dmax));
      write_reg(CSR_RECT_LEFT, {6'($urandom), 10'(left)});
      write_reg(CSR_RECT_TOP, {6'($urandom), 10'(top)});
      write_reg(CSR_RECT_WIDTH, {5'($urandom), 11'(w)});
      write_reg(CSR_RECT_HEIGHT, {5'($urandom), 11'(h)});
      if ($urandom_range(0, 2) == 0) begin
         write_reg($urandom_range(0, 1) ? SPARE_REG_A : SPARE_REG_B, 16'($urandom));
      end
   endtask

   // block until the pipeline is empty and nothing is outstanding
   task automatic wait_drained();
      do @(posedge clock);
      while (pixel_backlog.size() != 0 || req_valid || color_expect.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic push_pixel(input int d, input int col, input int row);
      req_type px;
      px.depth  = 16'(d);
      px.column = 10'(col);
      px.row    = 10'(row);
      pixel_backlog.push_back(px);
   endtask

   function automatic int clamp(input int v, input int lo, input int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // random setting per style; styles cover normal, reversed, empty and edge cases
   task automatic program_window(input int style);
      int a;
      int b;
      int dmin;
      int dmax;
      int left;
      int top;
      int w;
      int h;
      a    = $urandom_range(0, 65535);
      b    = $urandom_range(0, 65535);
      left = $urandom_range(0, 900);
      top  = $urandom_range(0, 900);
      w    = $urandom_range(1, 1024);
      h    = $urandom_range(1, 1024);
      dmin = (a < b) ? a : b;
      dmax = (a < b) ? b : a;
      case (style)
         0: begin
            dmin = 0;
            dmax = 65535;
            left = 0;
            top  = 0;
            w    = 1024;
            h    = 1024;
         end
         1: begin
            dmin = $urandom_range(0, 60000);
            dmax = dmin + $urandom_range(1, 4000);
         end
         2: begin
            // reversed range, sometimes the full span
            if ($urandom_range(0, 2) == 0) begin
               a = 0;
               b = 65535;
            end
            dmin = (a < b) ? b : a;
            dmax = (a < b) ? a : b;
            if (dmin == dmax) dmax = dmin - 1;
         end
         3: begin
            dmax = dmin;
            left = 0;
            top  = 0;
            w    = 1024;
            h    = 1024;
         end
         4: begin
            dmin = $urandom_range(3, 65532);
            dmax = $urandom_range(0, 1) ? dmin + $urandom_range(1, 3) :
                                         dmin - $urandom_range(1, 3);
         end
         5: begin
            left = $urandom_range(0, 1) ? 1023 : $urandom_range(900, 1023);
            top  = $urandom_range(0, 1023);
            w    = 1024;
            h    = $urandom_range(0, 1024);
         end
         6: begin
            left = $urandom_range(0, 1023);
            top  = $urandom_range(0, 1023);
            w    = $urandom_range(0, 1024);
            h    = $urandom_range(0, 1024);
         end
         default: begin
            if ($urandom_range(0, 1)) w = 0;
            else h = 0;
         end
      endcase
      write_window(clamp(dmin, 0, 65535), clamp(dmax, 0, 65535), left, top, w, h);
   endtask

   // depths mostly inside the active range, coordinates mostly inside the window
   task automatic queue_random_pixels(input int count);
      int lo;
      int hi;
      int c_lo;
      int c_hi;
      int r_lo;
      int r_hi;
      int d;
      int col;
      int row;
      int pick;
      int i;
      lo   = (cfg_depth_min < cfg_depth_max) ? cfg_depth_min : cfg_depth_max;
      hi   = (cfg_depth_min < cfg_depth_max) ? cfg_depth_max : cfg_depth_min;
      c_lo = cfg_rect_left;
      c_hi = clamp(int'(cfg_rect_left) + int'(cfg_rect_width) - 1, -1, 1023);
      r_lo = cfg_rect_top;
      r_hi = clamp(int'(cfg_rect_top) + int'(cfg_rect_height) - 1, -1, 1023);
      for (i = 0; i < count; i++) begin
         pick = $urandom_range(0, 9);
         if (pick <= 5) d = $urandom_range(hi, lo);
         else if (pick == 6) d = clamp(($urandom_range(0, 1) ? hi : lo) +
                                       $urandom_range(0, 4) - 2, 0, 65535);
         else if (pick <= 8) d = $urandom_range(0, 65535);
         else d = $urandom_range(0, 1) ? 65535 : 0;
         pick = $urandom_range(0, 9);
         if (c_hi >= c_lo && r_hi >= r_lo && pick <= 6) begin
            col = $urandom_range(c_hi, c_lo);
            row = $urandom_range(r_hi, r_lo);
         end else if (c_hi >= c_lo && r_hi >= r_lo && pick == 7) begin
            // just on or just off the window border
            case ($urandom_range(0, 3))
               0: col = c_lo - 1;
               1: col = c_lo;
               2: col = c_hi;
               default: col = c_hi + 1;
            endcase
            col = clamp(col, 0, 1023);
            row = $urandom_range(0, 1) ? r_lo : r_hi;
         end else begin
            col = $urandom_range(0, 1023);
            row = $urandom_range(0, 1023);
         end
         push_pixel(d, col, row);
      end
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------
   initial begin
      int k;
      int p;
      for (k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         quarter_wave[k] = quarter_sine(k);
      end
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // reset setting: empty window, gray everywhere
      @(posedge clock);
      push_pixel(0, 0, 0);
      push_pixel(255, 1023, 1023);
      push_pixel(256, 512, 0);
      push_pixel(65535, 0, 1023);
      wait_drained();

      // full range over the whole frame, segment boundaries
      write_window(0, 65535, 0, 0, 1024, 1024);
      @(posedge clock);
      push_pixel(0, 0, 0);
      push_pixel(16383, 1, 2);
      push_pixel(16384, 3, 4);
      push_pixel(16385, 5, 6);
      push_pixel(32767, 7, 8);
      push_pixel(32768, 9, 10);
      push_pixel(49152, 11, 12);
      push_pixel(49153, 13, 14);
      push_pixel(65535, 1023, 1023);
      wait_drained();

      // small window: out-of-range depths and window borders
      write_window(1000, 2000, 100, 200, 50, 10);
      @(posedge clock);
      push_pixel(999, 120, 205);
      push_pixel(2001, 120, 205);
      push_pixel(1000, 100, 200);
      push_pixel(2000, 149, 209);
      push_pixel(1500, 99, 205);
      push_pixel(1500, 150, 205);
      push_pixel(1500, 120, 210);
      wait_drained();

      // reversed range
      write_window(2000, 1000, 0, 0, 1024, 1024);
      @(posedge clock);
      push_pixel(2001, 5, 5);
      push_pixel(999, 5, 5);
      push_pixel(2000, 5, 5);
      push_pixel(1500, 5, 5);
      wait_drained();

      // empty range falls back to gray
      write_window(300, 300, 0, 0, 1024, 1024);
      @(posedge clock);
      push_pixel(300, 10, 10);
      push_pixel(5, 10, 10);
      wait_drained();

      // random phases; the last few run without idling
      for (p = 0; p < PHASE_COUNT; p++) begin
         idle_on = (p >= PHASE_COUNT - 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
         if (p == 1) idle_on = 1'b1;
         program_window((p < 8) ? p : $urandom_range(0, 7));
         @(posedge clock);
         queue_random_pixels(PHASE_ITEMS);
         // long receiver hold-off so the pipeline fills and stalls its input
         if (p == 1) sink_hold = HOLD_CYCLES;
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("[depth_rainbow_colorizer_core] OK");
      end else begin
         $display("[depth_rainbow_colorizer_core] ERROR");
      end
      $finish;
   end

endmodule

// File: depth_rainbow_colorizer_core.f
design/drc_pkg.sv
design/drc_prep.sv
design/drc_div.sv
design/drc_sine.sv
design/depth_rainbow_colorizer_core.sv
design/drc_checker.sv
verif/tb_top.sv
